@@ rtl/wcr_pkg.sv @@
// wcr_pkg: shared types, codes and helpers of the windowed content receiver
// no dependencies
package wcr_pkg;

    localparam int unsigned PAYLOAD_MAX   = 1024;
    localparam int unsigned TIMEOUT_RESET = 50000;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned QA_W          = $clog2(QUEUE_DEPTH);
    localparam int unsigned WIDE_W        = 48;

    localparam logic [1:0] A_START = 2'd0;
    localparam logic [1:0] A_DATA  = 2'd1;
    localparam logic [1:0] A_TICK  = 2'd2;

    localparam logic REG_PRESENT = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        K_WRITE  = 3'd0,
        K_ACK    = 3'd1,
        K_COMMIT = 3'd2,
        K_UPDATE = 3'd3,
        K_DONE   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] item_hash;
        logic [31:0] total_size;
        logic        buffer_granted;
        logic [15:0] window_number;
        logic [15:0] window_size;
        logic [15:0] packet_index;
        logic [15:0] payload_bytes;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] write_offset;
        logic [15:0] write_length;
        logic [15:0] ack_window;
        logic [15:0] ack_next;
        logic [31:0] ack_hash;
        logic        accepted;
        logic        last;
    } t_result;

    // packet count times payload size, widened
    function automatic logic [WIDE_W-1:0] pkt_bytes(input logic [15:0] v);
        pkt_bytes = WIDE_W'(v) * WIDE_W'(PAYLOAD_MAX);
    endfunction

endpackage

@@ rtl/wcr_item_if.sv @@
// wcr_item_if: input item channel, valid/ready plus item fields
// depends on nothing
interface wcr_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] item_hash;
    logic [31:0] total_size;
    logic        buffer_granted;
    logic [15:0] window_number;
    logic [15:0] window_size;
    logic [15:0] packet_index;
    logic [15:0] payload_bytes;

    modport source (output valid, action, item_hash, total_size, buffer_granted,
                    window_number, window_size, packet_index, payload_bytes,
                    input ready);
    modport sink (input valid, action, item_hash, total_size, buffer_granted,
                  window_number, window_size, packet_index, payload_bytes,
                  output ready);
endinterface

@@ rtl/wcr_res_if.sv @@
// wcr_res_if: result channel, valid/ready plus result fields
// depends on nothing
interface wcr_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] write_offset;
    logic [15:0] write_length;
    logic [15:0] ack_window;
    logic [15:0] ack_next;
    logic [31:0] ack_hash;
    logic        accepted;
    logic        last;

    modport source (output valid, kind, write_offset, write_length, ack_window,
                    ack_next, ack_hash, accepted, last, input ready);
    modport sink (input valid, kind, write_offset, write_length, ack_window,
                  ack_next, ack_hash, accepted, last, output ready);
endinterface

@@ rtl/windowed_content_receiver_unit.sv @@
// windowed_content_receiver_unit: top level, configuration registers, sequencer and
// result queue; depends on wcr_pkg, wcr_item_if, wcr_res_if, wcr_front, wcr_queue
// each item ends with a done result, pushed last; start and tick items go from IDLE
// straight to DONE, data items through the further steps of the sequencer in wcr_front;
// one more item is buffered meanwhile, the sequencer stalls while the queue is full,
// and a 4-entry result queue decouples output
// reset (synchronous, active low) clears all window state, empties the queue,
// sets receiver_present to 0 and timeout_ticks to 50000
module windowed_content_receiver_unit import wcr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wcr_item_if.sink    i_item,
    wcr_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    // configuration registers; the user must write them only while idle, which the block itself does not enforce
    logic        r_present;
    logic [19:0] r_timeout;

    // sequencer to queue
    logic        w_push;
    logic        w_full;
    t_result     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_timeout <= 20'(TIMEOUT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PRESENT: r_present <= i_cfg_data[0];
                REG_TIMEOUT: r_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: one buffered input transfer, multi-step sequencer per item,
    // stalls whenever the queue is full so no result is dropped
    wcr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_present (r_present),
        .i_timeout (r_timeout),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_res     (w_res)
    );

    // back: result queue drives the result channel
    wcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_res   (o_res)
    );

endmodule

@@ rtl/wcr_front.sv @@
// wcr_front: input buffer and sequencer that classifies items, keeps window state
// and pushes result items; depends on wcr_pkg and wcr_item_if
module wcr_front import wcr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wcr_item_if.sink     i_item,
    input  logic         i_present,
    input  logic [19:0]  i_timeout,
    input  logic         i_full,
    output logic         o_push,
    output t_result      o_res
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_D_CHK   = 8'b0000_0010,
        S_D_OPEN  = 8'b0000_0100,
        S_D_WIN   = 8'b0000_1000,
        S_D_WRITE = 8'b0001_0000,
        S_D_ACK   = 8'b0010_0000,
        S_D_FIN   = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state      r_state, n_state;
    logic        r_in_valid, n_in_valid;
    t_item       r_in;
    t_item       r_wk, n_wk;

    logic [31:0] r_bs, n_bs;
    logic [31:0] r_wb, n_wb;
    logic [15:0] r_cw, n_cw;
    logic [15:0] r_cwl, n_cwl;
    logic [15:0] r_ep, n_ep;
    logic        r_sup, n_sup;
    logic [31:0] r_held, n_held;
    logic        r_armed, n_armed;
    logic [19:0] r_tl, n_tl;

    logic        r_c1, n_c1;
    logic [31:0] r_nb, n_nb;
    logic [31:0] r_woff, n_woff;
    logic        r_wr_ok, n_wr_ok;
    logic        r_c2, n_c2;
    logic        r_acc, n_acc;

    logic [WIDE_W-1:0] w_pos, w_nb, w_sub, w_woff;
    logic [31:0]       w_room;
    logic [15:0]       w_ep_inc;
    logic [19:0]       w_tl_dec;
    logic [31:0]       w_hash;
    logic              w_in_take;

    assign i_item.ready = !r_in_valid;
    assign w_hash       = i_present ? r_held : 32'd0;
    assign w_pos        = WIDE_W'(r_wb) + pkt_bytes(r_ep);
    assign w_nb         = WIDE_W'(r_wb) + pkt_bytes(r_cwl);
    assign w_sub        = pkt_bytes(r_cwl);
    assign w_woff       = WIDE_W'(r_wb) + pkt_bytes(r_ep);
    assign w_room       = r_bs - r_woff;
    assign w_ep_inc     = r_ep + 16'd1;
    assign w_tl_dec     = (r_tl != 20'd0) ? r_tl - 20'd1 : r_tl;
    assign w_in_take    = (r_state == S_IDLE) && r_in_valid && !i_full;

    function automatic t_result mk(input t_kind k, input logic [31:0] off,
                                   input logic [15:0] len, input logic [15:0] win,
                                   input logic [15:0] unt, input logic [31:0] h,
                                   input logic acc, input logic lst);
        t_result r;
        r.kind         = k;
        r.write_offset = off;
        r.write_length = len;
        r.ack_window   = win;
        r.ack_next     = unt;
        r.ack_hash     = h;
        r.accepted     = acc;
        r.last         = lst;
        mk = r;
    endfunction

    always_comb begin
        n_state    = r_state;
        n_in_valid = r_in_valid;
        n_wk       = r_wk;
        n_bs       = r_bs;
        n_wb       = r_wb;
        n_cw       = r_cw;
        n_cwl      = r_cwl;
        n_ep       = r_ep;
        n_sup      = r_sup;
        n_held     = r_held;
        n_armed    = r_armed;
        n_tl       = r_tl;
        n_c1       = r_c1;
        n_nb       = r_nb;
        n_woff     = r_woff;
        n_wr_ok    = r_wr_ok;
        n_c2       = r_c2;
        n_acc      = r_acc;
        o_push     = 1'b0;
        o_res      = mk(K_DONE, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0);

        if (i_item.valid && !r_in_valid) begin
            n_in_valid = 1'b1;
        end

        if (!i_full) begin
            case (r_state)
                S_IDLE: begin
                    if (r_in_valid) begin
                        n_in_valid = 1'b0;
                        n_wk       = r_in;
                        n_acc      = 1'b0;
                        n_state    = S_DONE;
                        case (r_in.action)
                            A_START: begin
                                if (i_present) begin
                                    n_held  = r_in.item_hash;
                                    n_bs    = r_in.buffer_granted ? r_in.total_size : 32'd0;
                                    n_wb    = 32'd0;
                                    n_cw    = 16'd0;
                                    n_cwl   = 16'd0;
                                    n_ep    = 16'd0;
                                    n_sup   = 1'b0;
                                    n_armed = 1'b0;
                                    n_tl    = 20'd0;
                                    o_push  = 1'b1;
                                    o_res   = mk(K_UPDATE, 32'd0, 16'd0, 16'd0, 16'd0,
                                                 32'd0, 1'b0, 1'b0);
                                end
                            end
                            A_DATA: begin
                                if (i_present && (r_in.item_hash == r_held)) begin
                                    n_state = S_D_CHK;
                                end
                            end
                            A_TICK: begin
                                if (r_armed) begin
                                    n_tl = w_tl_dec;
                                    if (w_tl_dec == 20'd0) begin
                                        n_armed = 1'b0;
                                        o_push  = 1'b1;
                                        o_res   = mk(K_ACK, 32'd0, 16'd0, r_cw, r_ep,
                                                     w_hash, 1'b0, 1'b0);
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_D_CHK: begin
                    n_c1    = (w_pos >= WIDE_W'(r_bs));
                    n_nb    = (w_nb > WIDE_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w_nb[31:0];
                    n_state = S_D_OPEN;
                end
                S_D_OPEN: begin
                    if (r_c1) begin
                        n_state = S_DONE;
                    end else begin
                        n_armed = 1'b0;
                        n_tl    = 20'd0;
                        n_state = S_D_WIN;
                        if (r_ep == r_cwl) begin
                            n_wb  = r_nb;
                            n_cw  = (r_ep != 16'd0) ? r_cw + 16'd1 : r_cw;
                            n_cwl = r_wk.window_size;
                            n_ep  = 16'd0;
                            if (r_nb >= r_bs) begin
                                n_state = S_DONE;
                            end
                        end
                    end
                end
                S_D_WIN: begin
                    n_state = S_DONE;
                    if (r_wk.window_number != r_cw) begin
                        if ((r_wk.window_number == r_cw - 16'd1) &&
                            (r_wk.window_size != 16'd0) &&
                            (r_wk.packet_index + 16'd1 == r_wk.window_size)) begin
                            n_wb   = (w_sub > WIDE_W'(r_wb)) ? 32'd0 : r_wb - w_sub[31:0];
                            n_cw   = r_wk.window_number;
                            n_cwl  = r_wk.window_size;
                            n_ep   = r_wk.window_size;
                            o_push = 1'b1;
                            o_res  = mk(K_ACK, 32'd0, 16'd0, r_wk.window_number,
                                        r_wk.window_size, w_hash, 1'b0, 1'b0);
                        end
                    end else if (r_wk.packet_index != r_ep) begin
                        if (!r_sup) begin
                            n_sup  = 1'b1;
                            o_push = 1'b1;
                            o_res  = mk(K_ACK, 32'd0, 16'd0, r_cw, r_ep, w_hash,
                                        1'b0, 1'b0);
                        end
                    end else begin
                        n_sup   = 1'b0;
                        n_woff  = w_woff[31:0];
                        n_wr_ok = (w_woff < WIDE_W'(r_bs));
                        n_state = S_D_WRITE;
                    end
                end
                S_D_WRITE: begin
                    if (r_wr_ok) begin
                        o_push = 1'b1;
                        o_res  = mk(K_WRITE, r_woff,
                                    (w_room < 32'(r_wk.payload_bytes)) ? w_room[15:0]
                                                                        : r_wk.payload_bytes,
                                    16'd0, 16'd0, 32'd0, 1'b0, 1'b0);
                    end
                    n_ep    = w_ep_inc;
                    n_state = S_D_ACK;
                end
                S_D_ACK: begin
                    if (r_ep == r_cwl) begin
                        o_push = 1'b1;
                        o_res  = mk(K_ACK, 32'd0, 16'd0, r_cw, r_ep, w_hash, 1'b0, 1'b0);
                    end
                    n_c2    = (w_pos >= WIDE_W'(r_bs));
                    n_state = S_D_FIN;
                end
                S_D_FIN: begin
                    if (r_c2) begin
                        o_push = 1'b1;
                        o_res  = mk(K_COMMIT, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0,
                                    1'b0, 1'b0);
                    end else begin
                        n_armed = 1'b1;
                        n_tl    = i_timeout;
                    end
                    n_acc   = 1'b1;
                    n_state = S_DONE;
                end
                S_DONE: begin
                    o_push  = 1'b1;
                    o_res   = mk(K_DONE, 32'd0, 16'd0, 16'd0, 16'd0, 32'd0, r_acc, 1'b1);
                    n_state = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_valid <= 1'b0;
            r_bs       <= 32'd0;
            r_wb       <= 32'd0;
            r_cw       <= 16'd0;
            r_cwl      <= 16'd0;
            r_ep       <= 16'd0;
            r_sup      <= 1'b0;
            r_held     <= 32'd0;
            r_armed    <= 1'b0;
            r_tl       <= 20'd0;
            r_acc      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_valid <= n_in_valid;
            r_bs       <= n_bs;
            r_wb       <= n_wb;
            r_cw       <= n_cw;
            r_cwl      <= n_cwl;
            r_ep       <= n_ep;
            r_sup      <= n_sup;
            r_held     <= n_held;
            r_armed    <= n_armed;
            r_tl       <= n_tl;
            r_acc      <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && !r_in_valid) begin
            r_in.action         <= i_item.action;
            r_in.item_hash      <= i_item.item_hash;
            r_in.total_size     <= i_item.total_size;
            r_in.buffer_granted <= i_item.buffer_granted;
            r_in.window_number  <= i_item.window_number;
            r_in.window_size    <= i_item.window_size;
            r_in.packet_index   <= i_item.packet_index;
            r_in.payload_bytes  <= i_item.payload_bytes;
        end
        if (w_in_take) begin
            r_wk <= n_wk;
        end
        r_c1    <= n_c1;
        r_nb    <= n_nb;
        r_woff  <= n_woff;
        r_wr_ok <= n_wr_ok;
        r_c2    <= n_c2;
    end

endmodule

@@ rtl/wcr_queue.sv @@
// wcr_queue: result queue between sequencer and result channel
// depends on wcr_pkg and wcr_res_if
module wcr_queue import wcr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_res,
    output logic        o_full,
    wcr_res_if.source   o_res
);

    t_result           r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wr, n_wr;
    logic [QA_W-1:0]   r_rd, n_rd;
    logic [QA_W:0]     r_cnt, n_cnt;
    logic              w_pop;
    t_result           w_head;

    assign o_full  = (r_cnt == (QA_W+1)'(QUEUE_DEPTH));
    assign w_pop   = o_res.valid && o_res.ready;
    assign w_head  = r_mem[r_rd];

    assign o_res.valid        = (r_cnt != '0);
    assign o_res.kind         = w_head.kind;
    assign o_res.write_offset = w_head.write_offset;
    assign o_res.write_length = w_head.write_length;
    assign o_res.ack_window   = w_head.ack_window;
    assign o_res.ack_next     = w_head.ack_next;
    assign o_res.ack_hash     = w_head.ack_hash;
    assign o_res.accepted     = w_head.accepted;
    assign o_res.last         = w_head.last;

    always_comb begin
        n_wr  = (i_push) ? r_wr + QA_W'(1) : r_wr;
        n_rd  = (w_pop) ? r_rd + QA_W'(1) : r_rd;
        n_cnt = r_cnt + (QA_W+1)'(i_push) - (QA_W+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

@@ rtl/wcr_checker.sv @@
// wcr_checker: port-level assertions on the result channel, bound to the top level
// depends on wcr_pkg and windowed_content_receiver_unit
module wcr_checker import wcr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_kind,
    input logic [15:0] i_len,
    input logic        i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_kind <= K_DONE)
        else $error("bad result kind");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind != K_WRITE) |-> i_len == 16'd0)
        else $error("length on non-write result");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_kind == K_DONE)))
        else $error("last flag not on done result");

endmodule

bind windowed_content_receiver_unit wcr_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_kind  (o_res.kind),
    .i_len   (o_res.write_length),
    .i_last  (o_res.last)
);
